@@ src/mfw_pkg.sv @@
// Shared types and constants of the window median filter.
`default_nettype none

package mfw_pkg;

   // Field widths of the configuration registers and the item payloads
   localparam int SAMPLE_W   = 8;
   localparam int COORD_W    = 7;
   localparam int CHAN_W     = 2;
   localparam int WIDTH_W    = 8;
   localparam int HEIGHT_W   = 8;
   localparam int CHCOUNT_W  = 3;
   localparam int RADIUS_W   = 2;
   localparam int SIDE_W     = 3;
   localparam int RADIUS_REG_MAX = (1 << RADIUS_W) - 1;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
   localparam logic [1:0] REG_WINDOW_RADIUS = 2'd3;

   localparam logic [WIDTH_W-1:0]   FRAME_WIDTH_RST   = 8'd128;
   localparam logic [HEIGHT_W-1:0]  FRAME_HEIGHT_RST  = 8'd128;
   localparam logic [CHCOUNT_W-1:0] CHANNEL_COUNT_RST = 3'd1;
   localparam logic [RADIUS_W-1:0]  WINDOW_RADIUS_RST = 2'd1;

   // Operation and status codes
   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_QUERY     = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic [WIDTH_W-1:0]   frame_width;
      logic [HEIGHT_W-1:0]  frame_height;
      logic [CHCOUNT_W-1:0] channel_count;
      logic [RADIUS_W-1:0]  window_radius;
   } cfg_type;

   typedef struct packed {
      logic                opcode;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] median_value;
      logic                status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic init;
      logic issue;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic range_err;
      logic scan_last;
      logic pipe_empty;
   } ctrl_sts_type;

endpackage

`default_nettype wire

@@ src/median_filter_window.sv @@
// Sequence: a write visits only the window center, an out-of-range item skips the scan,
//   and a query of radius r scans every sample of its (2r+1) by (2r+1) window.
// Throughput: one item at a time; busy stays high from acceptance to the result strobe.
// The single port of the frame store and the one-insert-per-cycle sorter set the rate.
// Reset: synchronous, active high; idles the controller and loads the layout defaults.
//   Frame store contents are undefined until written; the receiver cannot stall.
`default_nettype none

module median_filter_window
   import mfw_pkg::*;
#(
   parameter int MAX_WIDTH    = 128,
   parameter int MAX_HEIGHT   = 128,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_RADIUS   = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   // Result channel: one beat per item, strobed for a single cycle
   output logic                       rsp_strobe,
   output rsp_type                    rsp_data,
   // Register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type      cfg_ff, cfg_in;
   logic         csr_wr;
   logic [1:0]   csr_index;
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // Register file: written on the access phase, never waits
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_FRAME_WIDTH:   cfg_in.frame_width   = pwdata[WIDTH_W-1:0];
            REG_FRAME_HEIGHT:  cfg_in.frame_height  = pwdata[HEIGHT_W-1:0];
            REG_CHANNEL_COUNT: cfg_in.channel_count = pwdata[CHCOUNT_W-1:0];
            REG_WINDOW_RADIUS: cfg_in.window_radius = pwdata[RADIUS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= FRAME_WIDTH_RST;
         cfg_ff.frame_height  <= FRAME_HEIGHT_RST;
         cfg_ff.channel_count <= CHANNEL_COUNT_RST;
         cfg_ff.window_radius <= WINDOW_RADIUS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the stored register value, zero extended
   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:   prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:  prdata = CSR_DATA_W'(cfg_ff.frame_height);
         REG_CHANNEL_COUNT: prdata = CSR_DATA_W'(cfg_ff.channel_count);
         REG_WINDOW_RADIUS: prdata = CSR_DATA_W'(cfg_ff.window_radius);
         default:           prdata = '0;
      endcase
   end

   // Sequence: load the item, check range and preset the sorter, scan the window,
   // drain the address pipeline, then strobe the result beat; an out-of-range item goes straight to the beat
   mfw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy),
      .done  (rsp_strobe)
   );

   mfw_datapath #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_RADIUS   (MAX_RADIUS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ src/mfw_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none

module mfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                     clock,
   input  wire logic                                     we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                         wdata,
   output logic      [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/mfw_sorter.sv @@
// Insertion sorter: a row of sorted sample slots with a fixed median tap.
`default_nettype none

module mfw_sorter
   import mfw_pkg::*;
#(
   parameter int DEPTH = 49
) (
   input  wire logic                             clock,
   input  wire logic                             init,
   input  wire logic [$clog2(DEPTH+1)-1:0]       pad_count,
   input  wire logic                             insert,
   input  wire logic [SAMPLE_W-1:0]              din,
   output logic      [SAMPLE_W-1:0]              median
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int MID   = (DEPTH - 1) / 2;

   logic [SAMPLE_W-1:0] slot_ff [DEPTH];
   logic [SAMPLE_W-1:0] slot_in [DEPTH];
   logic [DEPTH-1:0]    gt;

   // Each slot compares against the new sample on its own; larger ones shift up
   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      assign gt[i] = (slot_ff[i] > din);

      always_comb begin
         slot_in[i] = slot_ff[i];
         if (init) begin
            slot_in[i] = (pad_count > CNT_W'(i)) ? '0 : '1;
         end else if (insert && gt[i]) begin
            if (i == 0) begin
               slot_in[i] = din;
            end else begin
               slot_in[i] = gt[(i == 0) ? 0 : i-1] ? slot_ff[(i == 0) ? 0 : i-1] : din;
            end
         end
      end

      always_ff @(posedge clock) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign median = slot_ff[MID];

endmodule

`default_nettype wire

@@ src/mfw_datapath.sv @@
// Datapath: item hold, window scan, address pipeline, frame store, sorter.
`default_nettype none

module mfw_datapath
   import mfw_pkg::*;
#(
   parameter int MAX_WIDTH    = 128,
   parameter int MAX_HEIGHT   = 128,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_RADIUS   = 3
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire req_type      req_data,
   input  wire ctrl_cmd_type cmd,
   output ctrl_sts_type      sts,
   output rsp_type           rsp_data
);

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int FULL_W      = (ADDR_W > 20) ? ADDR_W : 20;
   localparam int RAD_MAX     = (MAX_RADIUS < RADIUS_REG_MAX) ? MAX_RADIUS : RADIUS_REG_MAX;
   localparam int WIN_CAP     = (2 * RAD_MAX + 1) * (2 * RAD_MAX + 1);
   localparam int CNT_W       = $clog2(WIN_CAP + 1);

   req_type                item_ff;
   logic [WIDTH_W-1:0]     w_eff;
   logic [HEIGHT_W-1:0]    h_eff;
   logic [CHCOUNT_W-1:0]   c_eff;
   logic [RADIUS_W-1:0]    r_eff;
   logic [SIDE_W-1:0]      side_m1;
   logic [2*SIDE_W-1:0]    win_count;
   logic [CNT_W-1:0]       pad_count;
   logic                   is_write;
   logic                   range_err;

   logic [SIDE_W-1:0]      ix_ff, ix_in;
   logic [SIDE_W-1:0]      iy_ff, iy_in;
   logic [9:0]             sx, sy;
   logic [WIDTH_W-1:0]     nx;
   logic [HEIGHT_W-1:0]    ny;

   logic                   va_ff, vb_ff, vc_ff;
   logic [15:0]            prod_a_ff;
   logic [WIDTH_W-1:0]     nx_a_ff;
   logic [16:0]            sum_b;
   logic [FULL_W-1:0]      addr_b_in, addr_b_ff;
   logic                   addr_ok;
   logic                   ok_c_ff;
   logic [SAMPLE_W-1:0]    rdata;
   logic [SAMPLE_W-1:0]    din;
   logic [SAMPLE_W-1:0]    median;

   // Clamp the layout registers into their legal ranges
   always_comb begin
      w_eff = cfg.frame_width;
      if (cfg.frame_width == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end
      h_eff = cfg.frame_height;
      if (cfg.frame_height == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end
      c_eff = cfg.channel_count;
      if (cfg.channel_count == '0) begin
         c_eff = CHCOUNT_W'(1);
      end else if (32'(cfg.channel_count) > MAX_CHANNELS) begin
         c_eff = CHCOUNT_W'(MAX_CHANNELS);
      end
      r_eff = cfg.window_radius;
      if (cfg.window_radius == '0) begin
         r_eff = RADIUS_W'(1);
      end else if (32'(cfg.window_radius) > RAD_MAX) begin
         r_eff = RADIUS_W'(RAD_MAX);
      end
   end

   assign side_m1   = {r_eff, 1'b0};
   assign win_count = (2*SIDE_W)'(side_m1 + SIDE_W'(1)) * (2*SIDE_W)'(side_m1 + SIDE_W'(1));
   assign pad_count = CNT_W'((WIN_CAP - 32'(win_count)) >> 1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   assign is_write  = (item_ff.opcode == OP_WRITE);
   assign range_err = ({1'b0, item_ff.col} >= w_eff) || ({1'b0, item_ff.row} >= h_eff)
                      || ({1'b0, item_ff.chan} >= c_eff);

   // Window scan counters; a write visits only the center
   always_comb begin
      ix_in = ix_ff;
      iy_in = iy_ff;
      if (cmd.init) begin
         ix_in = is_write ? SIDE_W'(r_eff) : '0;
         iy_in = is_write ? SIDE_W'(r_eff) : '0;
      end else if (cmd.issue) begin
         if (ix_ff == side_m1) begin
            ix_in = '0;
            iy_in = iy_ff + SIDE_W'(1);
         end else begin
            ix_in = ix_ff + SIDE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      ix_ff <= ix_in;
      iy_ff <= iy_in;
   end

   // Clamp the window coordinates to the frame edges
   assign sx = {3'b000, item_ff.col} + {7'b0, ix_ff} - {8'b0, r_eff};
   assign sy = {3'b000, item_ff.row} + {7'b0, iy_ff} - {8'b0, r_eff};

   always_comb begin
      if (sx[9]) begin
         nx = '0;
      end else if (sx[8:0] >= {1'b0, w_eff}) begin
         nx = w_eff - WIDTH_W'(1);
      end else begin
         nx = sx[7:0];
      end
      if (sy[9]) begin
         ny = '0;
      end else if (sy[8:0] >= {1'b0, h_eff}) begin
         ny = h_eff - HEIGHT_W'(1);
      end else begin
         ny = sy[7:0];
      end
   end

   // Address pipeline: row product, then column, channel scale and offset
   assign sum_b     = 17'(prod_a_ff) + 17'(nx_a_ff);
   assign addr_b_in = FULL_W'(sum_b) * FULL_W'(c_eff) + FULL_W'(item_ff.chan);
   assign addr_ok   = (32'(addr_b_ff) < STORE_DEPTH);

   always_ff @(posedge clock) begin
      prod_a_ff <= 16'(ny) * 16'(w_eff);
      nx_a_ff   <= nx;
      addr_b_ff <= addr_b_in;
      ok_c_ff   <= addr_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= cmd.issue;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   mfw_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (vb_ff && is_write && addr_ok),
      .addr  (addr_b_ff[ADDR_W-1:0]),
      .wdata (item_ff.sample),
      .rdata (rdata)
   );

   assign din = ok_c_ff ? rdata : '0;

   mfw_sorter #(
      .DEPTH (WIN_CAP)
   ) u_sorter (
      .clock     (clock),
      .init      (cmd.init),
      .pad_count (pad_count),
      .insert    (vc_ff && !is_write),
      .din       (din),
      .median    (median)
   );

   assign sts.range_err  = range_err;
   assign sts.scan_last  = is_write || ((ix_ff == side_m1) && (iy_ff == side_m1));
   assign sts.pipe_empty = !va_ff && !vb_ff && !vc_ff;

   assign rsp_data.median_value = (range_err || is_write) ? '0 : median;
   assign rsp_data.status       = range_err ? STATUS_RANGE : STATUS_OK;

endmodule

`default_nettype wire

@@ src/mfw_ctrl.sv @@
// Controller state machine: sequences one item through the datapath.
`default_nettype none

module mfw_ctrl
   import mfw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire ctrl_sts_type sts,
   output ctrl_cmd_type      cmd,
   output logic              busy,
   output logic              done
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_SCAN  = 5'b00100,
      S_DRAIN = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.init = 1'b1;
            state_in = sts.range_err ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (sts.pipe_empty) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

endmodule

`default_nettype wire
